// ----- rtl/core/sspg_pkg.sv -----
// Shared types and constants of the stepper step pulse generator.
`default_nettype none

package sspg_pkg;

    localparam logic [2:0] OP_TICK    = 3'd0;
    localparam logic [2:0] OP_STEP    = 3'd1;
    localparam logic [2:0] OP_ENABLE  = 3'd2;
    localparam logic [2:0] OP_DISABLE = 3'd3;
    localparam logic [2:0] OP_STOP    = 3'd4;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    localparam logic [CFG_IDX_W-1:0] REG_RPM           = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEPS_PER_REV = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MICROSTEPS    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HAS_END_STOPS = 2'd3;

    localparam int DIVIDEND_W = 26;
    localparam int DIVISOR_W  = 15;
    localparam logic [DIVIDEND_W-1:0] US_PER_MINUTE = 26'd60000000;

    typedef enum logic [1:0] {
        DSEL_RPM,
        DSEL_SPR,
        DSEL_MS
    } div_sel_t;

    typedef struct packed {
        logic     exec_op;
        logic     latch_cmd;
        logic     div_start;
        div_sel_t div_sel;
        logic     finish;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic room;
    } dp_status_t;

    typedef struct packed {
        logic        running;
        logic [31:0] steps_left;
        logic        enable_n;
        logic        direction;
        logic        step_pulse;
    } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/sspg_div.sv -----
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none

module sspg_div (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [sspg_pkg::DIVIDEND_W-1:0] dividend,
    input  wire logic [sspg_pkg::DIVISOR_W-1:0]  divisor,
    output logic                                done,
    output logic [sspg_pkg::DIVIDEND_W-1:0]      quotient
);
    import sspg_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  done_reg;
    logic [DIVISOR_W-1:0]  dvs_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  rem_next;
    logic [DIVIDEND_W-1:0] q_reg;
    logic [DIVIDEND_W-1:0] q_next;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;

    always_comb
    begin
        trial    = {rem_reg, q_reg[DIVIDEND_W-1]};
        diff     = trial - {1'b0, dvs_reg};
        fits     = trial >= {1'b0, dvs_reg};
        rem_next = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
        q_next   = {q_reg[DIVIDEND_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIVIDEND_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // The divisor is held for the whole division.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvs_reg <= divisor;
            rem_reg <= '0;
            q_reg   <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

`default_nettype wire

// ----- rtl/core/sspg_ctrl.sv -----
// Controller that sequences item acceptance and the interval divisions.
`default_nettype none

module sspg_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic [2:0]           in_opcode,
    output logic                      in_ready,
    output sspg_pkg::dp_cmd_t         cmd,
    input  wire sspg_pkg::dp_status_t status
);
    import sspg_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV_RPM,
        ST_DIV_SPR,
        ST_DIV_MS
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_ready = (state_reg == ST_IDLE) && status.room;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.div_sel = DSEL_RPM;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_opcode == OP_STEP)
                    begin
                        cmd.latch_cmd = 1'b1;
                        cmd.div_start = 1'b1;
                        cmd.div_sel   = DSEL_RPM;
                        state_next    = ST_DIV_RPM;
                    end
                    else
                    begin
                        cmd.exec_op = 1'b1;
                    end
                end
            end
            ST_DIV_RPM:
            begin
                if (status.div_done)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DSEL_SPR;
                    state_next    = ST_DIV_SPR;
                end
            end
            ST_DIV_SPR:
            begin
                if (status.div_done)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DSEL_MS;
                    state_next    = ST_DIV_MS;
                end
            end
            ST_DIV_MS:
            begin
                if (status.div_done)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/sspg_dp.sv -----
// Datapath: configuration, motion state, interval divider and output stage.
`default_nettype none

module sspg_dp #(
    parameter int INTERVAL_WIDTH = 26
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [sspg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [sspg_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic [2:0]                      in_opcode,
    input  wire logic [31:0]                     in_count,
    input  wire logic                            in_min,
    input  wire logic                            in_max,
    input  wire sspg_pkg::dp_cmd_t               cmd,
    output sspg_pkg::dp_status_t                 status,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output sspg_pkg::result_t                    out_data
);
    import sspg_pkg::*;

    localparam logic [32:0] IV_MAX = (33'd1 << INTERVAL_WIDTH) - 33'd1;

    logic [14:0] rpm_reg;
    logic [14:0] spr_reg;
    logic [8:0]  ms_reg;
    logic        has_end_stops_reg;

    logic [31:0]               remaining_reg;
    logic [31:0]               remaining_next;
    logic                      dir_reg;
    logic                      dir_next;
    logic                      active_reg;
    logic                      active_next;
    logic [INTERVAL_WIDTH-1:0] interval_reg;
    logic [INTERVAL_WIDTH-1:0] interval_next;
    logic [INTERVAL_WIDTH-1:0] tick_reg;
    logic [INTERVAL_WIDTH-1:0] tick_next;
    logic [31:0]               cnt_reg;

    logic                      pulse;
    logic                      blocked;
    logic [INTERVAL_WIDTH-1:0] tick_inc;
    logic [31:0]               magnitude;
    logic [32:0]               q_ext;
    logic [INTERVAL_WIDTH-1:0] iv_sat;

    logic [DIVIDEND_W-1:0] div_dividend;
    logic [DIVISOR_W-1:0]  div_divisor;
    logic [DIVISOR_W-1:0]  div_raw;
    logic                  div_done;
    logic [DIVIDEND_W-1:0] div_quotient;

    result_t result;
    logic    produce;
    logic    take;
    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rpm_reg           <= 15'd60;
            spr_reg           <= 15'd200;
            ms_reg            <= 9'd16;
            has_end_stops_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_RPM:           rpm_reg           <= cfg_wdata;
                REG_STEPS_PER_REV: spr_reg           <= cfg_wdata;
                REG_MICROSTEPS:    ms_reg            <= cfg_wdata[8:0];
                REG_HAS_END_STOPS: has_end_stops_reg <= cfg_wdata[0];
                default:           ;
            endcase
        end
    end

    // A divisor register that holds zero divides as one.
    always_comb
    begin
        case (cmd.div_sel)
            DSEL_RPM: div_raw = rpm_reg;
            DSEL_SPR: div_raw = spr_reg;
            DSEL_MS:  div_raw = {6'd0, ms_reg};
            default:  div_raw = rpm_reg;
        endcase
        div_divisor  = (div_raw == '0) ? DIVISOR_W'(1) : div_raw;
        div_dividend = (cmd.div_sel == DSEL_RPM) ? US_PER_MINUTE : div_quotient;
    end

    sspg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.latch_cmd)
        begin
            cnt_reg <= in_count;
        end
    end

    always_comb
    begin
        blocked   = has_end_stops_reg && (dir_reg ? in_min : in_max);
        tick_inc  = tick_reg + {{(INTERVAL_WIDTH-1){1'b0}}, 1'b1};
        magnitude = cnt_reg[31] ? (32'd0 - cnt_reg) : cnt_reg;
        q_ext     = {{(33-DIVIDEND_W){1'b0}}, div_quotient};
        iv_sat    = (q_ext > IV_MAX) ? IV_MAX[INTERVAL_WIDTH-1:0]
                                     : q_ext[INTERVAL_WIDTH-1:0];

        pulse          = 1'b0;
        remaining_next = remaining_reg;
        dir_next       = dir_reg;
        active_next    = active_reg;
        interval_next  = interval_reg;
        tick_next      = tick_reg;

        if (cmd.finish)
        begin
            dir_next      = ~cnt_reg[31];
            interval_next = iv_sat;
            active_next   = 1'b1;
            tick_next     = '0;
            if (magnitude != 32'd0)
            begin
                pulse          = 1'b1;
                remaining_next = magnitude - 32'd1;
            end
            else
            begin
                remaining_next = 32'd0;
            end
        end
        else if (cmd.exec_op)
        begin
            case (in_opcode)
                OP_TICK:
                begin
                    if (active_reg)
                    begin
                        if (tick_inc >= interval_reg)
                        begin
                            tick_next = '0;
                            if ((remaining_reg == 32'd0) || blocked)
                            begin
                                remaining_next = 32'd0;
                                active_next    = 1'b0;
                            end
                            else
                            begin
                                pulse          = 1'b1;
                                remaining_next = remaining_reg - 32'd1;
                            end
                        end
                        else
                        begin
                            tick_next = tick_inc;
                        end
                    end
                end
                OP_ENABLE:
                begin
                    active_next = 1'b1;
                    tick_next   = '0;
                end
                OP_DISABLE:
                begin
                    active_next = 1'b0;
                end
                OP_STOP:
                begin
                    remaining_next = 32'd0;
                    active_next    = 1'b0;
                end
                default: ;
            endcase
        end

        result.step_pulse = pulse;
        result.direction  = dir_next;
        result.enable_n   = ~active_next;
        result.steps_left = remaining_next;
        result.running    = active_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remaining_reg <= 32'd0;
            dir_reg       <= 1'b1;
            active_reg    <= 1'b0;
            interval_reg  <= '0;
            tick_reg      <= '0;
        end
        else
        begin
            remaining_reg <= remaining_next;
            dir_reg       <= dir_next;
            active_reg    <= active_next;
            interval_reg  <= interval_next;
            tick_reg      <= tick_next;
        end
    end

    // Output register with one skid entry behind it.
    assign produce = cmd.exec_op | cmd.finish;
    assign take    = out_valid_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= produce;
            end
        end
        else if (produce)
        begin
            if (out_valid_reg)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && skid_valid_reg)
        begin
            out_data_reg <= skid_data_reg;
        end
        else if (produce && (take || !out_valid_reg))
        begin
            out_data_reg <= result;
        end
        if (produce && out_valid_reg && !take)
        begin
            skid_data_reg <= result;
        end
    end

    assign status.div_done = div_done;
    assign status.room     = ~skid_valid_reg;
    assign out_valid       = out_valid_reg;
    assign out_data        = out_data_reg;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without a valid output entry");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        produce |-> !skid_valid_reg)
        else $error("result produced while the skid entry is full");

    a_finish_runs: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> (active_reg && out_valid_reg))
        else $error("step command did not start the motion");

    a_single_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.exec_op && (cmd.finish || cmd.div_start)))
        else $error("plain opcode overlaps a step command sequence");

endmodule

`default_nettype wire

// ----- rtl/core/stepper_step_pulse_generator.sv -----
// Top level of the stepper step pulse generator.
//
// Items enter on the s_ stream: s_tuser carries the opcode (tick, step
// command, enable, disable, stop) and s_tdata the signed step count and the
// two limit switch levels. Every accepted item yields exactly one result
// item on the m_ stream with the pulse flag, direction, driver enable,
// remaining steps and running flag after that item.
// Ticks, enable, disable and stop are accepted one per cycle while no step
// command runs and the skid entry is free, their result registered on acceptance.
// A step command runs three restoring divisions in series for the pulse
// interval; its result comes when the last one is done. The user must write
// the configuration port only while idle; the block itself does not enforce it.
// An output register with one skid entry decouples the sides: when the
// receiver stalls, one more item is still accepted, then s_tready drops
// until the output drains.
// Reset restores the default rpm, steps per revolution, microsteps and end
// stop setting, clears the step count, sets the positive direction and
// disables the driver.
`default_nettype none

module stepper_step_pulse_generator #(
    parameter int INTERVAL_WIDTH = 26
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [14:0] cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // Fields from bit 0: step_count[31:0], min_switch, max_switch, zero pad.
    input  wire logic [39:0] s_tdata,
    // Fields from bit 0: opcode[2:0].
    input  wire logic [2:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // Fields from bit 0: step_pulse, direction, enable_n, steps_left[31:0],
    // running, zero pad.
    output logic [39:0]      m_tdata
);
    import sspg_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    result_t    out_data;

    sspg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_opcode (s_tuser),
        .in_ready  (s_tready),
        .cmd       (cmd),
        .status    (status)
    );

    sspg_dp #(
        .INTERVAL_WIDTH (INTERVAL_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_opcode (s_tuser),
        .in_count  (s_tdata[31:0]),
        .in_min    (s_tdata[32]),
        .in_max    (s_tdata[33]),
        .cmd       (cmd),
        .status    (status),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign m_tdata = {4'd0, out_data};

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
// Self-checking testbench of the stepper step pulse generator with a predicting scoreboard.
module testbench;

    import sspg_pkg::*;

    localparam int IW = 26;
    localparam int unsigned INTERVAL_MAX = (32'd1 << IW) - 1;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int RANDOM_PHASES = 4;
    localparam int ITEMS_PER_PHASE = 250;

    localparam logic [2:0] OP_RSVD5 = 3'd5;
    localparam logic [2:0] OP_RSVD6 = 3'd6;
    localparam logic [2:0] OP_RSVD7 = 3'd7;

    class step_scoreboard;
        logic [14:0]   rpm;
        logic [14:0]   steps_per_rev;
        logic [8:0]    microsteps;
        logic          end_stops;
        logic [31:0]   remaining;
        logic          dir_level;
        logic          active;
        logic [IW-1:0] interval;
        logic [IW-1:0] ticks;
        result_t       expected_results[$];
        int            mismatches;
        int            stray_results;

        function new();
            rpm = 15'd60;
            steps_per_rev = 15'd200;
            microsteps = 9'd16;
            end_stops = 1'b1;
            remaining = '0;
            dir_level = 1'b1;
            active = 1'b0;
            interval = '0;
            ticks = '0;
            mismatches = 0;
            stray_results = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [14:0] val);
            case (idx)
                REG_RPM:           rpm = val;
                REG_STEPS_PER_REV: steps_per_rev = val;
                REG_MICROSTEPS:    microsteps = val[8:0];
                REG_HAS_END_STOPS: end_stops = val[0];
                default: ;
            endcase
        endfunction

        function int unsigned interval_for(int unsigned r, int unsigned s, int unsigned m);
            int unsigned q;
            q = US_PER_MINUTE / ((r == 0) ? 1 : r);
            q = q / ((s == 0) ? 1 : s);
            q = q / ((m == 0) ? 1 : m);
            if (q > INTERVAL_MAX)
                q = INTERVAL_MAX;
            return q;
        endfunction

        function void take_item(logic [2:0] op, logic [31:0] cnt, logic min_sw, logic max_sw);
            logic    pulse;
            logic    blocked;
            result_t r;
            pulse = 1'b0;
            case (op)
                OP_TICK:
                begin
                    if (active)
                    begin
                        ticks = ticks + 1'b1;
                        if (ticks >= interval)
                        begin
                            ticks = '0;
                            blocked = end_stops && (dir_level ? min_sw : max_sw);
                            if (remaining == 0 || blocked)
                            begin
                                remaining = '0;
                                active = 1'b0;
                            end
                            else
                            begin
                                pulse = 1'b1;
                                remaining = remaining - 1;
                            end
                        end
                    end
                end
                OP_STEP:
                begin
                    dir_level = !cnt[31];
                    remaining = cnt[31] ? (32'd0 - cnt) : cnt;
                    interval = IW'(interval_for(rpm, steps_per_rev, microsteps));
                    active = 1'b1;
                    ticks = '0;
                    if (remaining != 0)
                    begin
                        pulse = 1'b1;
                        remaining = remaining - 1;
                    end
                end
                OP_ENABLE:
                begin
                    active = 1'b1;
                    ticks = '0;
                end
                OP_DISABLE:
                    active = 1'b0;
                OP_STOP:
                begin
                    remaining = '0;
                    active = 1'b0;
                end
                default: ;
            endcase
            r.step_pulse = pulse;
            r.direction = dir_level;
            r.enable_n = !active;
            r.steps_left = remaining;
            r.running = active;
            expected_results.push_back(r);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_results.size() == 0)
            begin
                stray_results++;
                if (mismatches + stray_results <= 10)
                    $display("Unexpected result item: pulse %0b dir %0b en_n %0b left %0d run %0b",
                             got.step_pulse, got.direction, got.enable_n, got.steps_left,
                             got.running);
                return;
            end
            want = expected_results.pop_front();
            if (got.step_pulse !== want.step_pulse || got.direction !== want.direction ||
                got.enable_n !== want.enable_n || got.steps_left !== want.steps_left ||
                got.running !== want.running)
            begin
                mismatches++;
                if (mismatches + stray_results <= 10)
                    $display("Mismatch: expected pulse %0b dir %0b en_n %0b left %0d run %0b, got pulse %0b dir %0b en_n %0b left %0d run %0b",
                             want.step_pulse, want.direction, want.enable_n, want.steps_left,
                             want.running, got.step_pulse, got.direction, got.enable_n,
                             got.steps_left, got.running);
            end
        endfunction

        function int failures();
            return mismatches + stray_results + expected_results.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [14:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;

    step_scoreboard motion_board;
    int unsigned    cycle_count = 0;
    bit             tx_idle_on = 1'b1;
    bit             rx_idle_on = 1'b1;

    stepper_step_pulse_generator #(
        .INTERVAL_WIDTH(IW)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(negedge clk)
        m_tready <= !rx_idle_on || ($urandom_range(0, 99) >= 17);

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            motion_board.check_result(result_t'(m_tdata[35:0]));

    task automatic send_item(logic [2:0] op, logic [31:0] cnt, logic min_sw, logic max_sw);
        while (tx_idle_on && $urandom_range(0, 99) < 17)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {6'd0, max_sw, min_sw, cnt};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        motion_board.take_item(op, cnt, min_sw, max_sw);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (motion_board.expected_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_config(logic [14:0] r, logic [14:0] s, logic [8:0] m, logic e);
        cfg_we <= 1'b1;
        cfg_index <= REG_RPM;
        cfg_wdata <= r;
        motion_board.write_reg(REG_RPM, r);
        @(negedge clk);
        cfg_index <= REG_STEPS_PER_REV;
        cfg_wdata <= s;
        motion_board.write_reg(REG_STEPS_PER_REV, s);
        @(negedge clk);
        cfg_index <= REG_MICROSTEPS;
        cfg_wdata <= {6'd0, m};
        motion_board.write_reg(REG_MICROSTEPS, {6'd0, m});
        @(negedge clk);
        cfg_index <= REG_HAS_END_STOPS;
        cfg_wdata <= {14'd0, e};
        motion_board.write_reg(REG_HAS_END_STOPS, {14'd0, e});
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic random_config(logic e);
        int unsigned s;
        int unsigned m;
        int unsigned t;
        int unsigned r;
        s = $urandom_range(100, 2000);
        m = $urandom_range(1, 64);
        t = $urandom_range(0, 30);
        r = US_PER_MINUTE / ((t + 1) * s * m);
        if (r < 1)
            r = 1;
        if (r > 32767)
            r = 32767;
        write_config(r[14:0], s[14:0], m[8:0], e);
    endtask

    task automatic send_random_item();
        logic [2:0]  op;
        logic [31:0] cnt;
        int          sel;
        sel = $urandom_range(0, 99);
        cnt = $urandom;
        if (sel < 68)
            op = OP_TICK;
        else if (sel < 78)
        begin
            op = OP_STEP;
            case ($urandom_range(0, 9))
                7: cnt = $urandom;
                8:
                    case ($urandom_range(0, 3))
                        0: cnt = 32'h8000_0000;
                        1: cnt = 32'h7FFF_FFFF;
                        2: cnt = 32'd0;
                        default: cnt = 32'hFFFF_FFFF;
                    endcase
                9:
                begin
                    cnt = $urandom_range(0, 1000);
                    if ($urandom_range(0, 1))
                        cnt = 32'd0 - cnt;
                end
                default:
                begin
                    cnt = $urandom_range(0, 12);
                    if ($urandom_range(0, 1))
                        cnt = 32'd0 - cnt;
                end
            endcase
        end
        else if (sel < 84)
            op = OP_ENABLE;
        else if (sel < 89)
            op = OP_DISABLE;
        else if (sel < 94)
            op = OP_STOP;
        else
            case ($urandom_range(0, 2))
                0: op = OP_RSVD5;
                1: op = OP_RSVD6;
                default: op = OP_RSVD7;
            endcase
        send_item(op, cnt, $urandom_range(0, 99) < 8, $urandom_range(0, 99) < 8);
    endtask

    initial
    begin
        motion_board = new();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_RPM;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_TICK;
        m_tready = 1'b0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Default settings after reset.
        send_item(OP_STEP, 32'd2, 1'b0, 1'b0);
        send_item(OP_TICK, 32'd0, 1'b0, 1'b0);

        // Fastest settings: the interval is zero and expires on every tick.
        wait_idle();
        write_config(15'h7FFF, 15'h7FFF, 9'd256, 1'b1);
        send_item(OP_TICK, 32'hFFFF_FFFF, 1'b1, 1'b1);
        send_item(OP_RSVD5, 32'd0, 1'b0, 1'b0);
        send_item(OP_RSVD6, 32'd0, 1'b0, 1'b0);
        send_item(OP_RSVD7, 32'd0, 1'b0, 1'b0);
        send_item(OP_STEP, 32'd3, 1'b0, 1'b0);
        send_item(OP_TICK, 32'd0, 1'b0, 1'b0);
        send_item(OP_TICK, 32'd0, 1'b1, 1'b0);
        send_item(OP_STEP, 32'hFFFF_FFFE, 1'b0, 1'b0);
        send_item(OP_TICK, 32'd0, 1'b1, 1'b0);
        send_item(OP_TICK, 32'd0, 1'b0, 1'b1);
        send_item(OP_STEP, 32'd0, 1'b0, 1'b0);
        send_item(OP_TICK, 32'd0, 1'b0, 1'b0);
        send_item(OP_STEP, 32'h8000_0000, 1'b0, 1'b0);
        send_item(OP_DISABLE, 32'd0, 1'b0, 1'b0);
        send_item(OP_ENABLE, 32'd0, 1'b0, 1'b0);
        send_item(OP_TICK, 32'd0, 1'b0, 1'b0);
        send_item(OP_STOP, 32'd0, 1'b0, 1'b0);
        send_item(OP_STEP, 32'h7FFF_FFFF, 1'b0, 1'b0);
        send_item(OP_STEP, 32'hFFFF_FFFF, 1'b0, 1'b0);
        send_item(OP_TICK, 32'd0, 1'b0, 1'b0);

        // Zero divisors count as one; end stops are ignored.
        wait_idle();
        write_config(15'd0, 15'd0, 9'd0, 1'b0);
        send_item(OP_STEP, 32'd5, 1'b0, 1'b0);
        send_item(OP_TICK, 32'd0, 1'b1, 1'b1);
        send_item(OP_DISABLE, 32'd0, 1'b0, 1'b0);

        wait_idle();
        write_config(15'd1, 15'd1, 9'd1, 1'b1);
        send_item(OP_STEP, 32'hFFFF_FFFD, 1'b0, 1'b0);
        send_item(OP_STOP, 32'd0, 1'b0, 1'b0);

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            wait_idle();
            random_config(ph[0]);
            tx_idle_on = (ph != 2);
            rx_idle_on = (ph != 2);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                if (ph == 1 && i == ITEMS_PER_PHASE / 2)
                    wait_idle();
                send_random_item();
            end
        end

        wait_idle();
        repeat (20) @(negedge clk);
        if (motion_board.failures() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
